@@ rtl/trpd_pkg.sv @@
// Shared types and constants of the TGA RLE pixel decoder.
package trpd_pkg;

	// Pixel formats selected by the pixel_format register.
	typedef enum logic [1:0] {
		FMT_GRAY8    = 2'd0,
		FMT_ARGB1555 = 2'd1,
		FMT_BGR24    = 2'd2,
		FMT_BGRA32   = 2'd3
	} fmt_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
	localparam logic [1:0] CFG_RLE_ENABLE   = 2'd1;
	localparam logic [1:0] CFG_PIXEL_TOTAL  = 2'd2;

	localparam fmt_t        FMT_RESET         = FMT_BGR24;
	localparam logic [31:0] PIXEL_TOTAL_RESET = 32'd1;

	// Packet header layout: bit 7 marks a run, bits 6..0 hold count minus one.
	localparam int          RLE_RUN_BIT    = 7;
	localparam logic [6:0]  RLE_COUNT_MASK = 7'h7f;

	localparam logic [2:0]  CHAN_COUNT_3   = 3'd3;
	localparam logic [2:0]  CHAN_COUNT_4   = 3'd4;
	localparam logic [7:0]  ALPHA_FULL     = 8'd255;

	// Configuration as seen by the decode core.
	typedef struct packed {
		fmt_t        pixel_format;
		logic        rle_enable;
		logic [31:0] pixel_total;
	} cfg_t;

	// One decoded pixel word.
	typedef struct packed {
		logic [7:0] chan0;
		logic [7:0] chan1;
		logic [7:0] chan2;
		logic [7:0] chan3;
		logic [2:0] channel_count;
		logic [7:0] repeat_res;
		logic       image_done;
		logic       overrun;
	} pix_t;

endpackage

@@ rtl/trpd_core.sv @@
// Decode core: packet tracking, pixel assembly and image pixel counting.
module trpd_core
	import trpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_fire,
	input  logic [7:0] stream_byte,
	output logic       res_valid,
	output pix_t       res
);

	logic        expect_header_q;
	logic        run_packet_q;
	logic [7:0]  packet_left_q;
	logic [1:0]  byte_index_q;
	logic [7:0]  pixel_bytes_q [3];
	logic [31:0] pixels_done_q;

	logic        is_header;
	logic        is_partial;
	logic        is_pixel;
	logic        rle;
	logic        past_end;
	logic [31:0] remaining;
	logic        rem_one;
	logic [7:0]  run_req;
	logic        run_done;
	logic        run_over;
	logic [7:0]  pl_dec;
	logic [15:0] px16;
	logic [7:0]  rep;
	logic [7:0]  rep_add;
	logic        img_done;
	logic        ovr;
	logic [7:0]  pl_n;
	logic        eh_n;

	// Classify the incoming byte.
	assign rle        = cfg.rle_enable;
	assign is_header  = rle && expect_header_q;
	assign is_partial = !is_header && (byte_index_q < cfg.pixel_format);
	assign is_pixel   = !is_header && !is_partial;
	assign res_valid  = in_fire && is_pixel;

	// Pixels still owed to the image; taken as one when the counter has reached or passed the total.
	assign past_end  = pixels_done_q >= cfg.pixel_total;
	assign remaining = past_end ? 32'd1 : (cfg.pixel_total - pixels_done_q);
	assign rem_one   = (remaining == 32'd1);
	assign run_req   = packet_left_q;
	assign run_done  = {24'd0, run_req} >= remaining;
	assign run_over  = {24'd0, run_req} > remaining;
	assign pl_dec    = packet_left_q - 8'd1;

	// Repeat count, overrun and packet bookkeeping for a completed pixel.
	always_comb begin
		rep      = 8'd1;
		rep_add  = 8'd1;
		ovr      = 1'b0;
		img_done = rem_one;
		pl_n     = packet_left_q;
		eh_n     = expect_header_q;
		if (rle) begin
			if (run_packet_q) begin
				rep_add  = run_req;
				rep      = run_over ? remaining[7:0] : run_req;
				ovr      = run_over;
				img_done = run_done;
				pl_n     = 8'd0;
				eh_n     = 1'b1;
			end else begin
				pl_n = pl_dec;
				if (pl_dec == 8'd0) begin
					eh_n = 1'b1;
				end else if (rem_one) begin
					ovr = 1'b1;
				end
			end
		end
		if (img_done) begin
			pl_n = 8'd0;
			eh_n = 1'b1;
		end
	end

	// Channel mapping per pixel format.
	assign px16 = {stream_byte, pixel_bytes_q[0]};

	always_comb begin
		res.chan3         = 8'd0;
		res.channel_count = CHAN_COUNT_3;
		case (cfg.pixel_format)
			FMT_GRAY8: begin
				res.chan0 = stream_byte;
				res.chan1 = stream_byte;
				res.chan2 = stream_byte;
			end
			FMT_ARGB1555: begin
				res.chan0         = px16[15] ? ALPHA_FULL : 8'd0;
				res.chan1         = {px16[14:10], 3'b000};
				res.chan2         = {px16[9:5], 3'b000};
				res.chan3         = {px16[4:0], 3'b000};
				res.channel_count = CHAN_COUNT_4;
			end
			FMT_BGR24: begin
				res.chan0 = stream_byte;
				res.chan1 = pixel_bytes_q[1];
				res.chan2 = pixel_bytes_q[0];
			end
			default: begin
				res.chan0         = pixel_bytes_q[2];
				res.chan1         = pixel_bytes_q[1];
				res.chan2         = pixel_bytes_q[0];
				res.chan3         = stream_byte;
				res.channel_count = CHAN_COUNT_4;
			end
		endcase
		res.repeat_res = rep;
		res.image_done = img_done;
		res.overrun    = ovr;
	end

	// Stored leading bytes of the pixel being assembled.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (in_fire && is_partial && (byte_index_q == 2'(i))) begin
				pixel_bytes_q[i] <= stream_byte;
			end
		end
	end

	// Packet and image state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_header_q <= 1'b1;
			run_packet_q    <= 1'b0;
			packet_left_q   <= 8'd0;
			byte_index_q    <= 2'd0;
			pixels_done_q   <= 32'd0;
		end else if (in_fire) begin
			if (is_header) begin
				run_packet_q    <= stream_byte[RLE_RUN_BIT];
				packet_left_q   <= {1'b0, stream_byte[6:0] & RLE_COUNT_MASK} + 8'd1;
				expect_header_q <= 1'b0;
				byte_index_q    <= 2'd0;
			end else if (is_partial) begin
				byte_index_q <= byte_index_q + 2'd1;
			end else begin
				byte_index_q    <= 2'd0;
				packet_left_q   <= pl_n;
				expect_header_q <= eh_n;
				pixels_done_q   <= img_done ? 32'd0 : (pixels_done_q + {24'd0, rep_add});
			end
		end
	end

endmodule

@@ rtl/tga_rle_pixel_decoder.sv @@
// Top level of the TGA RLE pixel decoder: configuration registers and output buffering.
//
// Usage: image data bytes (after the file header) enter one per word on the
// input channel (in_valid, in_stall, stream_byte). Each completed pixel leaves
// as one word on the output channel (out_valid, out_stall, chan0..chan3,
// channel_count, repeat_res, image_done, overrun). Header bytes and leading
// pixel bytes produce no word.
// Configuration (pixel format, RLE mode, pixel total) is written through the
// cfg channel, which is always ready; write it only while the block is idle.
// Throughput: one byte per cycle while in_stall is low, set by the single
// decode stage between the input and the output register. The word of the
// completing byte is registered there, or in the skid register on a stall.
// A run packet yields one word carrying its repeat count, not repeated words.
// When the receiver stalls, the output word holds and one further word is
// caught in a skid register; in_stall rises while that register is full.
// Reset (arst_n low) clears packet state, the pixel counter and the valid
// flags of both output registers; it loads format BGR24, RLE off, pixel total one.
module tga_rle_pixel_decoder
	import trpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  chan0,
	output logic [7:0]  chan1,
	output logic [7:0]  chan2,
	output logic [7:0]  chan3,
	output logic [2:0]  channel_count,
	output logic [7:0]  repeat_res,
	output logic        image_done,
	output logic        overrun,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t cfg_q;
	logic in_fire;
	logic res_valid;
	pix_t res;
	logic out_valid_q;
	pix_t out_q;
	logic skid_valid_q;
	pix_t skid_q;
	logic out_free;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format <= FMT_RESET;
			cfg_q.rle_enable   <= 1'b0;
			cfg_q.pixel_total  <= PIXEL_TOTAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_PIXEL_FORMAT: cfg_q.pixel_format <= fmt_t'(cfg_data[1:0]);
				CFG_RLE_ENABLE:   cfg_q.rle_enable   <= cfg_data[0];
				CFG_PIXEL_TOTAL:  cfg_q.pixel_total  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode stage.
	assign in_stall = skid_valid_q;
	assign in_fire  = in_valid && !in_stall;

	trpd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_fire     (in_fire),
		.stream_byte (stream_byte),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Output register with a skid stage behind it.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || res_valid;
			skid_valid_q <= 1'b0;
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign chan0         = out_q.chan0;
	assign chan1         = out_q.chan1;
	assign chan2         = out_q.chan2;
	assign chan3         = out_q.chan3;
	assign channel_count = out_q.channel_count;
	assign repeat_res    = out_q.repeat_res;
	assign image_done    = out_q.image_done;
	assign overrun       = out_q.overrun;

endmodule

@@ rtl/trpd_checker.sv @@
// Port-level checks of the TGA RLE pixel decoder and their binding.
module trpd_checker
	import trpd_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] chan0,
	input logic [7:0] chan1,
	input logic [7:0] chan2,
	input logic [7:0] chan3,
	input logic [2:0] channel_count,
	input logic [7:0] repeat_res,
	input logic       image_done,
	input logic       overrun
);

	// A stalled word stays on the output unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(chan0) && $stable(chan1)
			&& $stable(chan2) && $stable(chan3) && $stable(repeat_res))
		else $error("stalled output word changed");

	// A three-channel word carries no fourth channel.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && channel_count == CHAN_COUNT_3 |-> chan3 == 8'd0)
		else $error("fourth channel set on a three-channel word");

	// Repeat count lies in the packet range.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> repeat_res != 8'd0 && repeat_res <= 8'd128)
		else $error("repeat count out of range");

	// An overrunning packet always ends the image.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overrun |-> image_done)
		else $error("overrun without image completion");

endmodule

bind tga_rle_pixel_decoder trpd_checker u_trpd_checker (.*);

@@ dv/tb.sv @@
// Self-checking testbench for the TGA RLE pixel decoder: directed cases, then random streams.
module tb;
	import trpd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] TOTAL_MAX   = 32'd4294836225;
	localparam int          RANDOM_BYTES = 880;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  stream_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  chan0;
	logic [7:0]  chan1;
	logic [7:0]  chan2;
	logic [7:0]  chan3;
	logic [2:0]  channel_count;
	logic [7:0]  repeat_res;
	logic        image_done;
	logic        overrun;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	tga_rle_pixel_decoder u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.stream_byte   (stream_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.chan0         (chan0),
		.chan1         (chan1),
		.chan2         (chan2),
		.chan3         (chan3),
		.channel_count (channel_count),
		.repeat_res    (repeat_res),
		.image_done    (image_done),
		.overrun       (overrun),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Mirror of the configuration registers.
	fmt_t        cur_fmt;
	logic        cur_rle;
	logic [31:0] cur_total;

	// Mirror of the decoder state.
	logic        hdr_pending;
	logic        run_mode;
	logic [7:0]  pkt_remaining;
	logic [1:0]  byte_pos;
	logic [7:0]  pix_hold [3];
	logic [31:0] pix_count;

	pix_t expected_pixels [$];
	int   mismatches;
	bit   no_idle;

	// Free-running clock.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Run limit, far above the slowest correct run.
	initial begin
		#10_000_000;
		$display("tb: FAIL");
		$finish;
	end

	// Gap length: mostly none or short, now and then long.
	function automatic int unsigned gap_len();
		int unsigned r;
		if (no_idle) return 0;
		r = $urandom_range(99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(10, 4);
		return $urandom_range(40, 11);
	endfunction

	// Predict the pixel word, if any, caused by one accepted byte.
	function automatic bit decode_byte(input logic [7:0] b, output pix_t px);
		int          bpp;
		logic [15:0] px16;
		logic [31:0] remaining;
		logic [31:0] reps;
		bpp = int'(cur_fmt) + 1;
		px = '0;
		reps = 32'd1;

		// A header byte opens a packet.
		if (cur_rle && hdr_pending) begin
			run_mode = b[RLE_RUN_BIT];
			pkt_remaining = {1'b0, b[6:0] & RLE_COUNT_MASK} + 8'd1;
			hdr_pending = 1'b0;
			byte_pos = 2'd0;
			return 1'b0;
		end

		// Leading bytes of a pixel are only stored.
		if (int'(byte_pos) < bpp - 1) begin
			pix_hold[byte_pos] = b;
			byte_pos = byte_pos + 2'd1;
			return 1'b0;
		end
		byte_pos = 2'd0;

		// Assemble the channels of the completed pixel.
		px.channel_count = CHAN_COUNT_3;
		case (cur_fmt)
			FMT_GRAY8: begin
				px.chan0 = b;
				px.chan1 = b;
				px.chan2 = b;
			end
			FMT_ARGB1555: begin
				px16 = {b, pix_hold[0]};
				px.chan0 = px16[15] ? ALPHA_FULL : 8'd0;
				px.chan1 = {px16[14:10], 3'b000};
				px.chan2 = {px16[9:5], 3'b000};
				px.chan3 = {px16[4:0], 3'b000};
				px.channel_count = CHAN_COUNT_4;
			end
			FMT_BGR24: begin
				px.chan0 = b;
				px.chan1 = pix_hold[1];
				px.chan2 = pix_hold[0];
			end
			default: begin
				px.chan0 = pix_hold[2];
				px.chan1 = pix_hold[1];
				px.chan2 = pix_hold[0];
				px.chan3 = b;
				px.channel_count = CHAN_COUNT_4;
			end
		endcase

		// With the counter at or past the total, one pixel is taken to remain.
		remaining = (pix_count < cur_total) ? cur_total - pix_count : 32'd1;

		// Packet bookkeeping; runs are clamped to the end of the image.
		if (cur_rle) begin
			if (run_mode) begin
				reps = {24'd0, pkt_remaining};
				if (reps > remaining) begin
					reps = remaining;
					px.overrun = 1'b1;
				end
				pkt_remaining = 8'd0;
				hdr_pending = 1'b1;
			end else begin
				pkt_remaining = pkt_remaining - 8'd1;
				if (pkt_remaining == 8'd0) hdr_pending = 1'b1;
				else if (remaining == 32'd1) px.overrun = 1'b1;
			end
		end

		// Completing the image restarts the counter and the packet parser.
		if (reps >= remaining) begin
			px.image_done = 1'b1;
			pix_count = 32'd0;
			pkt_remaining = 8'd0;
			hdr_pending = 1'b1;
		end else begin
			pix_count = pix_count + reps;
		end
		px.repeat_res = reps[7:0];
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("tb: mismatch at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
		if (got !== want) report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// Output checker: each accepted word against the oldest expectation.
	always @(posedge clk) begin : pixel_check
		pix_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("pixel word with nothing expected");
			end else begin
				want = expected_pixels.pop_front();
				check_field("chan0", chan0, want.chan0);
				check_field("chan1", chan1, want.chan1);
				check_field("chan2", chan2, want.chan2);
				check_field("chan3", chan3, want.chan3);
				check_field("channel_count", {5'd0, channel_count}, {5'd0, want.channel_count});
				check_field("repeat_res", repeat_res, want.repeat_res);
				check_field("image_done", {7'd0, image_done}, {7'd0, want.image_done});
				check_field("overrun", {7'd0, overrun}, {7'd0, want.overrun});
			end
		end
	end

	// Receiver stalls in bursts of random length.
	initial begin
		int unsigned n;
		out_stall = 1'b0;
		forever begin
			n = gap_len();
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat (gap_len() + 1) @(posedge clk);
		end
	end

	// Send one byte after a random gap and predict its effect on acceptance.
	task automatic send_byte(input logic [7:0] b);
		int unsigned gap;
		pix_t        px;
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (in_stall);
		if (decode_byte(b, px)) expected_pixels.push_back(px);
	endtask

	// Stop sending and let every expected word and any pending byte drain.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// One register write; valid stays high so writes can follow back to back.
	task automatic write_one(input logic [1:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PIXEL_FORMAT: cur_fmt = fmt_t'(val[1:0]);
			CFG_RLE_ENABLE:   cur_rle = val[0];
			CFG_PIXEL_TOTAL:  cur_total = val;
			default: ;
		endcase
	endtask

	// Write the selected registers once the block is idle.
	task automatic program_regs(input bit [2:0] sel, input fmt_t f, input logic rle,
			input logic [31:0] total);
		wait_idle();
		if (sel[0]) write_one(CFG_PIXEL_FORMAT, {30'd0, f});
		if (sel[1]) write_one(CFG_RLE_ENABLE, {31'd0, rle});
		if (sel[2]) write_one(CFG_PIXEL_TOTAL, total);
		if (sel != 3'b000) cfg_valid <= 1'b0;
	endtask

	// Every pixel format with RLE off; extreme byte values for gray and ARGB1555.
	task automatic test_formats();
		program_regs(3'b111, FMT_GRAY8, 1'b0, 32'd4);
		send_byte(8'h00);
		send_byte(8'hff);
		program_regs(3'b001, FMT_ARGB1555, 1'b0, 32'd0);
		send_byte(8'h00);
		send_byte(8'h80);
		send_byte(8'hff);
		send_byte(8'h7f);
		program_regs(3'b001, FMT_BGR24, 1'b0, 32'd0);
		send_byte(8'h01);
		send_byte(8'h02);
		send_byte(8'h03);
		program_regs(3'b001, FMT_BGRA32, 1'b0, 32'd0);
		send_byte(8'ha0);
		send_byte(8'hb1);
		send_byte(8'hc2);
		send_byte(8'hd3);
	endtask

	// A run packet and a raw packet.
	task automatic test_rle_packets();
		program_regs(3'b111, FMT_GRAY8, 1'b1, 32'd10);
		send_byte(8'h81);
		send_byte(8'h55);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'hff);
	endtask

	// Packets that reach past the end of the image.
	task automatic test_image_end();
		program_regs(3'b100, FMT_GRAY8, 1'b1, 32'd3);
		// Longest run, clamped to what is left.
		send_byte(8'hff);
		send_byte(8'h77);
		// Raw packet of six into an image of three; the rest is dropped.
		send_byte(8'h05);
		send_byte(8'h10);
		send_byte(8'h20);
		send_byte(8'h30);
		// The next byte is a header again.
		send_byte(8'h80);
		send_byte(8'h40);
	endtask

	// Configuration changes in the middle of an image, a pixel or a packet.
	task automatic test_config_midstream();
		// Total lowered below the counter.
		program_regs(3'b111, FMT_GRAY8, 1'b0, 32'd200);
		send_byte(8'h11);
		program_regs(3'b100, FMT_GRAY8, 1'b0, 32'd1);
		send_byte(8'h22);
		// Format shrunk after two bytes of a four-byte pixel.
		program_regs(3'b101, FMT_BGRA32, 1'b0, 32'd50);
		send_byte(8'h5a);
		send_byte(8'ha5);
		program_regs(3'b001, FMT_GRAY8, 1'b0, 32'd0);
		send_byte(8'h3c);
		// RLE switched off inside a raw packet and back on.
		program_regs(3'b010, FMT_GRAY8, 1'b1, 32'd0);
		send_byte(8'h02);
		send_byte(8'h44);
		program_regs(3'b010, FMT_GRAY8, 1'b0, 32'd0);
		send_byte(8'h66);
		program_regs(3'b010, FMT_GRAY8, 1'b1, 32'd0);
		send_byte(8'h88);
		send_byte(8'h99);
	endtask

	// Next random byte: mostly a well-formed header where one is due, else random.
	function automatic logic [7:0] next_stream_byte();
		int unsigned r;
		logic [6:0]  count;
		r = $urandom_range(99);
		if (r < 10 || !(cur_rle && hdr_pending)) return 8'($urandom_range(255));
		r = $urandom_range(99);
		if (r < 70) count = 7'($urandom_range(7));
		else if (r < 90) count = 7'($urandom_range(31, 8));
		else count = 7'($urandom_range(127, 32));
		return {1'($urandom_range(1)), count};
	endfunction

	// Random phases, each with its own configuration.
	task automatic test_random();
		int          sent;
		int          burst;
		int unsigned r;
		logic [31:0] total;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			r = $urandom_range(99);
			if (r < 20) total = 32'd1;
			else if (r < 30) total = TOTAL_MAX;
			else if (r < 40) total = $urandom_range(TOTAL_MAX, 1);
			else total = $urandom_range(30, 1);
			program_regs(3'b111, fmt_t'($urandom_range(3)), ($urandom_range(99) < 70), total);
			no_idle = ($urandom_range(4) == 0);
			burst = $urandom_range(100, 40);
			repeat (burst) send_byte(next_stream_byte());
			sent += burst;
			no_idle = 1'b0;
		end
	endtask

	// Reset, tests in turn, drain and verdict.
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		stream_byte = 8'd0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PIXEL_FORMAT;
		cfg_data = 32'd0;
		mismatches = 0;
		no_idle = 1'b0;
		cur_fmt = FMT_RESET;
		cur_rle = 1'b0;
		cur_total = PIXEL_TOTAL_RESET;
		hdr_pending = 1'b1;
		run_mode = 1'b0;
		pkt_remaining = 8'd0;
		byte_pos = 2'd0;
		pix_count = 32'd0;
		foreach (pix_hold[i]) pix_hold[i] = 8'd0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_formats();
		test_rle_packets();
		test_image_end();
		test_config_midstream();
		test_random();

		wait_idle();
		repeat (5) @(posedge clk);
		if (mismatches == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

endmodule
